// File: hw/rtl/tea_pkg.sv
`default_nettype none

package tea_pkg;

    // Number of TEA iterations; each iteration is two half-rounds
    localparam int CYCLES = 32;
    localparam int NUM_STAGES = 2 * CYCLES;

    // Golden-ratio round constant
    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    // Key register indexes on the configuration port
    localparam logic [1:0] KEY_IDX_0 = 2'd0;
    localparam logic [1:0] KEY_IDX_1 = 2'd1;
    localparam logic [1:0] KEY_IDX_2 = 2'd2;
    localparam logic [1:0] KEY_IDX_3 = 2'd3;

    // Word pair moving down the cell chain: a is updated, b feeds the mix
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } tea_pair_t;

    // Status of the output buffer seen by the chain control
    typedef struct packed {
        logic full;
        logic has_data;
    } tea_buf_status_t;

    // Running sum for a given stage: stage pair r uses (r + 1) * delta
    function automatic logic [31:0] tea_stage_sum(input int stage);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'((stage >> 1) + 1);
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tea_cell.sv
`default_nettype none

module tea_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire tea_pkg::tea_pair_t in_pair,
    input  wire logic [31:0]        sum,
    input  wire logic [31:0]        key_l,
    input  wire logic [31:0]        key_r,
    output      logic               out_valid,
    output      tea_pkg::tea_pair_t out_pair
);
    import tea_pkg::*;

    logic      valid_reg;
    tea_pair_t pair_reg;
    tea_pair_t pair_next;
    logic [31:0] mix;

    // Mix the partner word and update, then swap roles for the next cell
    always_comb
    begin
        mix = ((in_pair.b << 4) + key_l) ^ (in_pair.b + sum) ^ ((in_pair.b >> 5) + key_r);
        pair_next.a = in_pair.b;
        pair_next.b = in_pair.a + mix;
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg <= pair_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pair  = pair_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tea_out_buf.sv
`default_nettype none

module tea_out_buf (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire tea_pkg::tea_pair_t       push_pair,
    input  wire logic                     pop,
    output      tea_pkg::tea_pair_t       head_pair,
    output      tea_pkg::tea_buf_status_t status
);
    import tea_pkg::*;

    tea_pair_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pair;
        end
    end

    assign head_pair       = entry_reg[rd_ptr_reg];
    assign status.full     = (count_reg == 2'd2);
    assign status.has_data = (count_reg != 2'd0);

endmodule

`default_nettype wire

// File: hw/rtl/tea_block_encrypt_unit.sv
`default_nettype none

// TEA block encryption: one 64-bit block (plain_first, plain_second) in,
// one ciphertext block out, under the 128-bit key in key words 0..3 written
// through key_we/key_index/key_data. The rounds run down a chain of 64 cells,
// one half-round each, so a new request is taken every cycle unless the chain
// is frozen. A request is loaded into the first cell at the accepting edge,
// passes through the other 63 cells in order, and its result is then written
// into the output buffer, where it shows on the output.
// A two-entry output buffer lets requests keep flowing while one result
// waits; the chain freezes only when both entries are held under out_stall.
// Write the key only while no request is in flight.
module tea_block_encrypt_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_we,
    input  wire logic [1:0]  key_index,
    input  wire logic [31:0] key_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [31:0] plain_first,
    input  wire logic [31:0] plain_second,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [31:0] cipher_first,
    output      logic [31:0] cipher_second
);
    import tea_pkg::*;

    logic [31:0] key_reg [4];

    logic            chain_en;
    logic            stage_valid [NUM_STAGES + 1];
    tea_pair_t       stage_pair  [NUM_STAGES + 1];
    logic            buf_pop;
    tea_pair_t       head_pair;
    tea_buf_status_t buf_status;

    // Hold the key words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= 32'd0;
            key_reg[1] <= 32'd0;
            key_reg[2] <= 32'd0;
            key_reg[3] <= 32'd0;
        end
        else if (key_we)
        begin
            unique case (key_index)
                KEY_IDX_0: key_reg[0] <= key_data;
                KEY_IDX_1: key_reg[1] <= key_data;
                KEY_IDX_2: key_reg[2] <= key_data;
                KEY_IDX_3: key_reg[3] <= key_data;
                default:   key_reg[0] <= key_reg[0];
            endcase
        end
    end

    // Freeze the chain only when the output buffer is full and held
    assign buf_pop  = buf_status.has_data && !out_stall;
    assign chain_en = !(buf_status.full && out_stall);
    assign in_stall = !chain_en;

    // Feed the chain
    assign stage_valid[0]  = in_valid;
    assign stage_pair[0].a = plain_first;
    assign stage_pair[0].b = plain_second;

    // Chain of half-round cells: even cells update the first word, odd the second
    for (genvar j = 0; j < NUM_STAGES; j++)
    begin : g_cell
        localparam logic [31:0] STAGE_SUM = tea_stage_sum(j);
        localparam int KEY_BASE = (j % 2 == 0) ? 0 : 2;

        tea_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (chain_en),
            .in_valid  (stage_valid[j]),
            .in_pair   (stage_pair[j]),
            .sum       (STAGE_SUM),
            .key_l     (key_reg[KEY_BASE]),
            .key_r     (key_reg[KEY_BASE + 1]),
            .out_valid (stage_valid[j + 1]),
            .out_pair  (stage_pair[j + 1])
        );
    end

    // Buffer finished blocks
    tea_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (chain_en && stage_valid[NUM_STAGES]),
        .push_pair (stage_pair[NUM_STAGES]),
        .pop       (buf_pop),
        .head_pair (head_pair),
        .status    (buf_status)
    );

    assign out_valid     = buf_status.has_data;
    assign cipher_first  = head_pair.a;
    assign cipher_second = head_pair.b;

endmodule

`default_nettype wire

// File: hw/rtl/tea_checker.sv
`default_nettype none

module tea_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] cipher_first,
    input wire logic [31:0] cipher_second
);

    // A held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cipher_first)
            && $stable(cipher_second))
        else $error("held result changed");

    // Input stalls only under output backpressure
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A stalled request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled request withdrawn");

endmodule

bind tea_block_encrypt_unit tea_checker u_tea_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second)
);

`default_nettype wire

// File: verif/tea_block_encrypt_unit_test.sv
`default_nettype none

module tea_block_encrypt_unit_test;

    import tea_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_ITEMS    = 150;
    localparam int RANDOM_PHASES  = 6;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } word_pair_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        key_we        = 1'b0;
    logic [1:0]  key_index     = KEY_IDX_0;
    logic [31:0] key_data      = 32'h0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [31:0] plain_first   = 32'h0;
    logic [31:0] plain_second  = 32'h0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;

    // Key copy used by the predictor, plaintext waiting to go, ciphertext awaited
    logic [31:0] key_word [4];
    word_pair_t  plain_queue [$];
    word_pair_t  cipher_expected [$];

    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  no_idle        = 1'b0;

    tea_block_encrypt_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_we        (key_we),
        .key_index     (key_index),
        .key_data      (key_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .plain_first   (plain_first),
        .plain_second  (plain_second),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_first  (cipher_first),
        .cipher_second (cipher_second)
    );

    always #4 clk = ~clk;

    // Encrypt one block under the current key copy
    function automatic word_pair_t tea_encipher(input word_pair_t plain);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        word_pair_t  res;
        y   = plain.first;
        z   = plain.second;
        sum = 32'h0;
        for (int i = 0; i < CYCLES; i++)
        begin
            sum = sum + TEA_DELTA;
            y = y + (((z << 4) + key_word[0]) ^ (z + sum) ^ ((z >> 5) + key_word[1]));
            z = z + (((y << 4) + key_word[2]) ^ (y + sum) ^ ((y >> 5) + key_word[3]));
        end
        res.first  = y;
        res.second = z;
        return res;
    endfunction

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Word biased toward edge values
    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_block(input logic [31:0] first, input logic [31:0] second);
        word_pair_t blk;
        blk.first  = first;
        blk.second = second;
        plain_queue.push_back(blk);
    endtask

    // Hold until every request is taken and every result is back
    task automatic wait_drained();
        while (plain_queue.size() != 0 || cipher_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        key_we    <= 1'b1;
        key_index <= idx;
        key_data  <= val;
        key_word[idx] = val;
    endtask

    // Load the whole key while the block is idle
    task automatic load_key(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
        wait_drained();
        repeat (4) @(posedge clk);
        write_key(KEY_IDX_0, w0);
        write_key(KEY_IDX_1, w1);
        write_key(KEY_IDX_2, w2);
        write_key(KEY_IDX_3, w3);
        @(posedge clk);
        key_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_edge_blocks();
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(32'h0000_0000, 32'hFFFF_FFFF);
        queue_block(32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Driver: present queued plaintext, hold it while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                cipher_expected.push_back(tea_encipher(plain_queue.pop_front()));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (plain_queue.size() > 0)
                begin
                    in_valid     <= 1'b1;
                    plain_first  <= plain_queue[0].first;
                    plain_second <= plain_queue[0].second;
                    if (!no_idle && $urandom_range(0, 2) == 0)
                        send_gap = gap_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_expected.size() == 0)
                begin
                    report_error($sformatf("unexpected result %h %h",
                                           cipher_first, cipher_second));
                end
                else
                begin
                    word_pair_t exp_blk;
                    exp_blk = cipher_expected.pop_front();
                    if (cipher_first !== exp_blk.first)
                        report_error($sformatf("cipher_first got %h exp %h",
                                               cipher_first, exp_blk.first));
                    if (cipher_second !== exp_blk.second)
                        report_error($sformatf("cipher_second got %h exp %h",
                                               cipher_second, exp_blk.second));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = gap_len() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
            key_word[i] = 32'h0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key of all zeros: edge words and a few patterns
        queue_edge_blocks();
        queue_block(32'h0000_0001, 32'h0000_0000);
        queue_block(32'h0000_0000, 32'h0000_0001);
        queue_block(32'h8000_0000, 32'h8000_0000);
        queue_block(32'hAAAA_AAAA, 32'h5555_5555);
        queue_block(32'h1234_5678, 32'h9ABC_DEF0);

        // All-ones key, then an explicit all-zero key
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_edge_blocks();
        queue_block(32'h5555_5555, 32'hAAAA_AAAA);
        load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_edge_blocks();

        // Random phases, each under its own key
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: load_key(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
                1: load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
                default: load_key($urandom, $urandom, $urandom, $urandom);
            endcase
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Pause halfway until all results are back
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                queue_block(rand_word(), rand_word());
            end
            wait_drained();
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (cipher_expected.size() != 0)
            report_error("results still outstanding at end of run");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/tea_pkg.sv
hw/rtl/tea_cell.sv
hw/rtl/tea_out_buf.sv
hw/rtl/tea_block_encrypt_unit.sv
hw/rtl/tea_checker.sv
verif/tea_block_encrypt_unit_test.sv
